// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

   localparam int unsigned MAX_FRAMES_DEFAULT = 4096;
   // frame indexes are 12 bits wide
   localparam int unsigned INDEX_LIMIT = 4096;
   localparam logic [12:0] FRAME_COUNT_RESET = 13'd4096;
   // register select is paddr[2]
   localparam logic REG_FRAME_COUNT = 1'b0;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_TEST    = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_NOT_USED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_MODIFY,
      S_SCAN,
      S_DONE
   } fsm_type;

endpackage

// ===== rtl/bitmap_frame_allocator.sv =====
// free, test, reserve: the word passes S_READ and S_MODIFY, one byte read-modify-write, then S_DONE.
// allocate: S_SCAN reads bitmap bytes (up to 512 by default), one byte per cycle on the
// single read port; out-of-range word or zero frame count goes straight to S_DONE. one item at a time,
// next word taken once the result is registered.
// reset is synchronous; afterwards a clearing pass writes zeros to every bitmap byte, one per
// cycle ((MAX_FRAMES+7)/8 bytes, 512 by default), and no word is accepted until it ends.
module bitmap_frame_allocator #(
   parameter int unsigned MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], frame_index[13:2], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_frame[11:0], in_use[12], status[14:13],
                                    // used_frames[27:15], zero fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bfa_pkg::*;

   localparam int unsigned BYTES = (MAX_FRAMES + 7) / 8;
   localparam int unsigned AW = (BYTES > 1) ? $clog2(BYTES) : 1;
   localparam int unsigned LIMIT = (MAX_FRAMES < INDEX_LIMIT) ? MAX_FRAMES : INDEX_LIMIT;
   localparam logic [AW-1:0] LAST_BYTE = AW'(BYTES - 1);

   fsm_type     state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [11:0] frame_ff, frame_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] daddr_ff, daddr_in;
   logic        dvalid_ff, dvalid_in;
   logic [7:0]  rd_data_ff;
   logic [12:0] count_ff, count_in;
   logic [11:0] res_frame_ff, res_frame_in;
   logic        res_use_ff, res_use_in;
   status_type  res_st_ff, res_st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [12:0] frame_count_ff, frame_count_in;

   logic [7:0]  bitmap_mem [BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic        req_accept;
   cmd_type     req_cmd;
   logic [11:0] req_frame;
   logic [12:0] active_n;
   logic [12:0] n_minus;
   logic [AW-1:0] last_addr;
   logic        req_out_of_range;
   logic [AW-1:0] map_row;
   logic [7:0]  bit_mask;
   logic        cur_bit;
   logic [31:0] lane_base;
   logic [7:0]  free_lane;
   logic        found_any;
   logic [2:0]  found_k;
   logic [11:0] found_frame;
   logic        scan_last;
   logic        rsp_load;
   logic        csr_write;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_count_in = frame_count_ff;
      if (csr_write && csr_paddr[2] == REG_FRAME_COUNT) begin
         frame_count_in = csr_pwdata[12:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FRAME_COUNT) ? {19'd0, frame_count_ff} : 32'd0;

   // ---------------- shared decode ----------------
   assign active_n  = (frame_count_ff > 13'(LIMIT)) ? 13'(LIMIT) : frame_count_ff;
   assign n_minus   = active_n - 13'd1;
   assign last_addr = AW'(n_minus[12:3]);

   assign req_accept       = req_tvalid && req_tready;
   assign req_cmd          = cmd_type'(req_tdata[1:0]);
   assign req_frame        = req_tdata[13:2];
   assign req_out_of_range = {1'b0, req_frame} >= active_n;

   assign map_row  = AW'(frame_ff[11:3]);
   assign bit_mask = 8'b1 << frame_ff[2:0];
   assign cur_bit  = rd_data_ff[frame_ff[2:0]];

   // lowest free bit of the byte under inspection, limited to frames in range
   assign lane_base = 32'(daddr_ff) << 3;

   always_comb begin
      found_k = 3'd0;
      for (int k = 0; k < 8; k++) begin
         free_lane[k] = !rd_data_ff[k] && ((lane_base + 32'(k)) < 32'(active_n));
      end
      for (int k = 7; k >= 0; k--) begin
         if (free_lane[k]) found_k = 3'(k);
      end
   end

   assign found_any   = |free_lane;
   assign found_frame = 12'(lane_base + 32'(found_k));
   assign scan_last   = (daddr_ff == last_addr);
   assign rsp_load    = !rsp_valid_ff || rsp_tready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == LAST_BYTE) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_ALLOC) begin
                  state_in = (active_n == 13'd0) ? S_DONE : S_SCAN;
               end else begin
                  state_in = req_out_of_range ? S_DONE : S_READ;
               end
            end
         end
         S_READ:   state_in = S_MODIFY;
         S_MODIFY: state_in = S_DONE;
         S_SCAN: begin
            if (dvalid_ff && (found_any || scan_last)) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      req_tready   = 1'b0;
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      ptr_in       = ptr_ff;
      daddr_in     = daddr_ff;
      dvalid_in    = dvalid_ff;
      count_in     = count_ff;
      res_frame_in = res_frame_ff;
      res_use_in   = res_use_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = map_row;
      mem_wdata    = rd_data_ff;
      mem_raddr    = (state_ff == S_SCAN) ? ptr_ff : map_row;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = 8'd0;
            ptr_in    = ptr_ff + AW'(1);
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               cmd_in       = req_cmd;
               frame_in     = req_frame;
               ptr_in       = '0;
               dvalid_in    = 1'b0;
               res_frame_in = req_frame;
               res_use_in   = 1'b1;
               res_st_in    = STAT_OK;
               if (req_cmd == CMD_ALLOC) begin
                  res_frame_in = 12'd0;
                  if (active_n == 13'd0) res_st_in = STAT_FULL;
               end else if (req_out_of_range) begin
                  res_st_in = STAT_RANGE;
               end
            end
         end
         S_READ: begin
         end
         S_MODIFY: begin
            case (cmd_ff)
               CMD_FREE: begin
                  res_use_in = 1'b0;
                  if (cur_bit) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_data_ff & ~bit_mask;
                     count_in  = count_ff - 13'd1;
                  end else begin
                     res_st_in = STAT_NOT_USED;
                  end
               end
               CMD_TEST: res_use_in = cur_bit;
               CMD_RESERVE: begin
                  if (!cur_bit) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_data_ff | bit_mask;
                     count_in  = count_ff + 13'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // read of byte ptr overlaps inspection of the byte read in the previous cycle
            dvalid_in = 1'b1;
            daddr_in  = ptr_ff;
            if (ptr_ff != last_addr) ptr_in = ptr_ff + AW'(1);
            if (dvalid_ff) begin
               if (found_any) begin
                  mem_we       = 1'b1;
                  mem_waddr    = daddr_ff;
                  mem_wdata    = rd_data_ff | (8'b1 << found_k);
                  count_in     = count_ff + 13'd1;
                  res_frame_in = found_frame;
               end else if (scan_last) begin
                  res_st_in = STAT_FULL;
               end
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, count_ff, res_st_ff, res_use_ff, res_frame_ff};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         ptr_ff         <= '0;
         dvalid_ff      <= 1'b0;
         count_ff       <= 13'd0;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= FRAME_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         dvalid_ff      <= dvalid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_count_ff <= frame_count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      frame_ff     <= frame_in;
      daddr_ff     <= daddr_in;
      res_frame_ff <= res_frame_in;
      res_use_ff   <= res_use_in;
      res_st_ff    <= res_st_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bitmap_mem[mem_raddr];
   end

endmodule

// ===== rtl/bfa_checker.sv =====
`include "assert_macros.svh"

module bfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import bfa_pkg::*;

   // one word in flight: busy right after taking a word
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // a waiting result stays up
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `ASSERT_SAME(a_full_shape, clock, reset, rsp_tvalid && rsp_tdata[14:13] == STAT_FULL,
                rsp_tdata[12] && rsp_tdata[11:0] == 12'd0)

   `ASSERT_SAME(a_not_used_clear, clock, reset,
                rsp_tvalid && rsp_tdata[14:13] == STAT_NOT_USED, !rsp_tdata[12])

   `ASSERT_SAME(a_count_bound, clock, reset, rsp_tvalid, rsp_tdata[27:15] <= 13'd4096)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/bitmap_frame_allocator_test.sv =====
`timescale 1ns / 100ps

module bitmap_frame_allocator_test;
   import bfa_pkg::*;

   localparam logic [2:0] ADDR_FRAME_COUNT = {REG_FRAME_COUNT, 2'b00};
   localparam logic [2:0] ADDR_UNKNOWN     = {~REG_FRAME_COUNT, 2'b00};

   typedef struct packed {
      logic [11:0] frame;
      cmd_type     op;
   } frame_op_type;

   typedef struct packed {
      logic [11:0] frame;
      logic        in_use;
      logic [1:0]  status;
      logic [12:0] used;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // command[1:0], frame_index[13:2], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result_frame[11:0], in_use[12], status[14:13],
                             // used_frames[27:15], zero fill
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   bit          frame_map [4096];
   logic [12:0] used_tally;
   logic [12:0] frame_limit;

   frame_op_type     pending_words [$];
   frame_result_type expected_results [$];
   frame_op_type     req_word;
   bit          req_fired;
   int          idle_pct;
   int          words_queued;
   int          results_seen;
   int          error_count;

   bitmap_frame_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int active_frames();
      return (frame_limit > INDEX_LIMIT) ? int'(INDEX_LIMIT) : int'(frame_limit);
   endfunction

   function automatic frame_result_type apply_frame_op(input frame_op_type w);
      frame_result_type r;
      int n;
      int i;
      n = active_frames();
      r.frame  = w.frame;
      r.in_use = 1'b1;
      r.status = STAT_OK;
      if (w.op == CMD_ALLOC) begin
         r.frame = '0;
         for (i = 0; i < n; i++)
            if (!frame_map[i]) break;
         if (i < n) begin
            frame_map[i] = 1'b1;
            used_tally++;
            r.frame = i[11:0];
         end else begin
            r.status = STAT_FULL;
         end
      end else if (int'(w.frame) >= n) begin
         r.status = STAT_RANGE;
      end else if (w.op == CMD_FREE) begin
         r.in_use = 1'b0;
         if (frame_map[w.frame]) begin
            frame_map[w.frame] = 1'b0;
            used_tally--;
         end else begin
            r.status = STAT_NOT_USED;
         end
      end else if (w.op == CMD_TEST) begin
         r.in_use = frame_map[w.frame];
      end else if (!frame_map[w.frame]) begin
         frame_map[w.frame] = 1'b1;
         used_tally++;
      end
      r.used = used_tally;
      return r;
   endfunction

   // driver: words and result stalls change at the falling edge
   always @(negedge clock) begin : drive_words
      frame_op_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fired) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, nxt.frame, nxt.op};
               req_word   <= nxt;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
      req_fired = 1'b0;
   end

   // monitor: results checked before the accepted word is predicted
   always @(posedge clock) begin : watch_words
      frame_result_type got;
      frame_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[11:0], rsp_tdata[12], rsp_tdata[14:13], rsp_tdata[27:15]};
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, frame", int'(got.frame), -1);
            end else begin
               want = expected_results.pop_front();
               if (got.frame !== want.frame)
                  report_mismatch("result_frame", int'(got.frame), int'(want.frame));
               if (got.in_use !== want.in_use)
                  report_mismatch("in_use", int'(got.in_use), int'(want.in_use));
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.used !== want.used)
                  report_mismatch("used_frames", int'(got.used), int'(want.used));
            end
         end
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            expected_results.push_back(apply_frame_op(req_word));
         end
      end
   end

   task automatic queue_word(input cmd_type op, input int frame);
      frame_op_type w;
      w.op    = op;
      w.frame = frame[11:0];
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_random_word();
      int n;
      int roll;
      int f;
      cmd_type op;
      n = active_frames();
      roll = $urandom_range(0, 99);
      if (roll < 35) op = CMD_ALLOC;
      else if (roll < 60) op = CMD_FREE;
      else if (roll < 80) op = CMD_TEST;
      else op = CMD_RESERVE;
      roll = $urandom_range(0, 99);
      if (roll < 70) f = $urandom_range(0, (n == 0) ? 3 : ((n < 96) ? n : 96));
      else if (roll < 85) f = $urandom_range(0, 4095);
      else f = ((n == 0) ? 0 : n - 1) + $urandom_range(0, 1);
      if (f > 4095) f = 4095;
      queue_word(op, f);
   endtask

   // sender pauses here until every queued word has its result
   task automatic wait_drained();
      while (results_seen != words_queued) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_FRAME_COUNT) frame_limit = value[12:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_frame_count();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_FRAME_COUNT;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {19'b0, frame_limit})
         report_mismatch("frame_count readback", int'(csr_prdata), int'(frame_limit));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input int setting, input int items, input int idle);
      wait_drained();
      idle_pct = idle;
      write_register(ADDR_FRAME_COUNT, setting);
      check_frame_count();
      repeat (items) queue_random_word();
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_word     = '0;
      req_fired    = 1'b0;
      idle_pct     = 11;
      words_queued = 0;
      results_seen = 0;
      error_count  = 0;
      used_tally   = '0;
      frame_limit  = FRAME_COUNT_RESET;
      foreach (frame_map[i]) frame_map[i] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all frames managed after reset
      queue_word(CMD_TEST, 0);
      queue_word(CMD_FREE, 0);          // free of a frame never used
      queue_word(CMD_ALLOC, 0);
      queue_word(CMD_ALLOC, 4095);
      queue_word(CMD_RESERVE, 4095);
      queue_word(CMD_RESERVE, 4095);    // already used
      queue_word(CMD_TEST, 4095);
      queue_word(CMD_FREE, 4095);
      queue_word(CMD_FREE, 1);
      queue_word(CMD_ALLOC, 0);
      queue_word(CMD_RESERVE, 2);
      queue_word(CMD_RESERVE, 3);
      queue_word(CMD_ALLOC, 0);
      queue_word(CMD_TEST, 2730);
      queue_word(CMD_TEST, 1365);
      queue_word(CMD_RESERVE, 100);

      // write to an unmapped register must leave frame_count alone
      wait_drained();
      write_register(ADDR_UNKNOWN, 32'd5);
      check_frame_count();
      queue_word(CMD_TEST, 4095);

      // shrink below a used frame, then fill up
      wait_drained();
      write_register(ADDR_FRAME_COUNT, 8);
      check_frame_count();
      queue_word(CMD_TEST, 8);
      queue_word(CMD_RESERVE, 4095);
      queue_word(CMD_FREE, 100);
      queue_word(CMD_TEST, 100);
      repeat (4) queue_word(CMD_ALLOC, 0);

      // nothing managed at all
      wait_drained();
      write_register(ADDR_FRAME_COUNT, 0);
      check_frame_count();
      queue_word(CMD_ALLOC, 0);
      queue_word(CMD_TEST, 0);

      run_phase(37, 120, 11);
      run_phase(1, 40, 11);
      run_phase(8191, 120, 11);
      queue_word(CMD_FREE, 100);
      run_phase(300, 130, 11);
      run_phase(8, 70, 11);
      run_phase(4096, 200, 0);
      run_phase(2, 40, 11);
      run_phase(1000, 130, 11);
      run_phase(0, 20, 11);
      run_phase(64, 120, 11);
      run_phase(4096, 150, 11);

      wait_drained();
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(50_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
